// ----- rtl/lbdr_pkg.sv -----
// ----------------------------------------------------------------------------
// lbdr_pkg
// Shared codes and constants for the lockout debounce and button remap block.
// ----------------------------------------------------------------------------
`default_nettype none

package lbdr_pkg;

    // Request opcodes
    localparam logic OP_SAMPLE    = 1'b0;
    localparam logic OP_MAP_WRITE = 1'b1;

    // Configuration register indexes: windows first, then masks, one per port
    localparam logic [1:0] REG_WIN_BASE  = 2'd0;
    localparam logic [1:0] REG_MASK_BASE = 2'd2;

    // Field widths fixed by the interface
    localparam int WORD_W   = 32;
    localparam int WIN_W    = 8;
    localparam int SHIFT_W  = 6;
    localparam int PINSEL_W = 5;

    // Largest legal map value (button bit 31 plus one)
    localparam logic [SHIFT_W-1:0] MAP_MAX = 6'd32;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [SHIFT_W-1:0] shift_t;

endpackage : lbdr_pkg

`default_nettype wire

// ----- rtl/lbdr_ram.sv -----
// ----------------------------------------------------------------------------
// lbdr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lbdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : lbdr_ram

`default_nettype wire

// ----- rtl/lockout_button_debounce_remap_top.sv -----
// ----------------------------------------------------------------------------
// lockout_button_debounce_remap_top
// Eager-lockout debounce of GPIO pins with per-pin button remapping.
// ----------------------------------------------------------------------------
// A sample request keeps in_ready low from acceptance until its result is
// closed out, so a new sample is not taken before then: one pin per cycle
// goes through a single shared lockout compare, with the lockout-time and
// pin-map memories read in the cycle before the compare, then a close-out
// step that waits for the result register to be free.
// A map-write request returns nothing; a request for a port not below PORTS
// is taken and dropped. Both memories reset to zero via per-entry valid bits,
// so no clearing pass is needed after reset. Registers may only be written
// while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module lockout_button_debounce_remap_top
    import lbdr_pkg::*;
#(
    parameter int PORTS = 2,
    parameter int PINS  = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,

    // Configuration write port
    input  wire logic                cfg_wr_en,
    input  wire logic [1:0]          cfg_addr,
    input  wire logic [WORD_W-1:0]   cfg_wdata,

    // Request channel
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                opcode,
    input  wire logic                port,
    input  wire logic [WORD_W-1:0]   gpio_levels,
    input  wire logic [WORD_W-1:0]   now_ms,
    input  wire logic [PINSEL_W-1:0] map_pin,
    input  wire logic [SHIFT_W-1:0]  map_shift,

    // Result channel
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [WORD_W-1:0]        filtered_pins,
    output logic [WORD_W-1:0]        buttons,
    output logic                     report_changed
);

    localparam int DEPTH  = PORTS * PINS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PIN_W  = (PINS > 1) ? $clog2(PINS) : 1;
    localparam int CNT_W  = $clog2(PINS + 1);
    localparam logic [WORD_W-1:0] PIN_PRESENT = {WORD_W{1'b1}} >> (WORD_W - PINS);

    // Sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_WALK   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Configuration
    logic [WIN_W-1:0] win_cfg_reg  [PORTS];
    word_t            mask_cfg_reg [PORTS];

    // Per-port state
    logic [PINS-1:0]  acc_reg  [PORTS];
    logic [PINS-1:0]  last_reg [PORTS];
    word_t            btn_reg  [PORTS];

    // Working copy of the request in flight
    logic             port_reg;
    logic [PINS-1:0]  pins_reg;
    logic [PINS-1:0]  chg_reg;
    logic [WIN_W-1:0] win_reg;
    word_t            now_reg;
    word_t            until_reg;

    // Valid bits standing in for the memories' reset
    logic [DEPTH-1:0] lock_vld_reg;
    logic [DEPTH-1:0] map_vld_reg;
    logic             lock_rd_vld_reg;
    logic             map_rd_vld_reg;

    // Result register
    logic             out_valid_reg;
    word_t            out_pins_reg;
    word_t            out_btn_reg;
    logic             out_chg_reg;

    function automatic logic [ADDR_W-1:0] entry_addr(input logic p, input logic [PIN_W-1:0] n);
        entry_addr = ADDR_W'(int'(p) * PINS + int'(n));
    endfunction

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    logic            in_fire;
    logic            port_ok;
    logic            start_sample;
    logic            map_wr;
    word_t           mask_in;
    logic [PINS-1:0] pins_in;

    assign in_ready     = (state_reg == S_IDLE);
    assign in_fire      = in_valid && in_ready;
    assign port_ok      = (int'(port) < PORTS);
    assign start_sample = in_fire && port_ok && (opcode == OP_SAMPLE);
    assign map_wr       = in_fire && port_ok && (opcode == OP_MAP_WRITE)
                          && (int'(map_pin) < PINS);
    assign mask_in      = mask_cfg_reg[port] & PIN_PRESENT;
    assign pins_in      = PINS'(~gpio_levels & mask_in);

    // ------------------------------------------------------------------
    // Memory addressing: read pin cnt, evaluate pin cnt-1
    // ------------------------------------------------------------------
    logic [PIN_W-1:0]  rd_pin;
    logic [PIN_W-1:0]  ev_pin;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] ev_addr;
    logic [ADDR_W-1:0] map_waddr;

    assign rd_pin    = (int'(cnt_reg) < PINS) ? PIN_W'(cnt_reg) : '0;
    assign ev_pin    = PIN_W'(cnt_reg - 1'b1);
    assign rd_addr   = entry_addr(port_reg, rd_pin);
    assign ev_addr   = entry_addr(port_reg, ev_pin);
    assign map_waddr = entry_addr(port, PIN_W'(map_pin));

    word_t  lock_rdata;
    shift_t map_rdata;
    shift_t map_wdata;

    assign map_wdata = (map_shift <= MAP_MAX) ? map_shift : '0;

    // ------------------------------------------------------------------
    // Shared lockout compare and toggle logic
    // ------------------------------------------------------------------
    logic   eval_en;
    logic   take;
    logic   lock_we;
    word_t  lock_cur;
    shift_t map_cur;
    word_t  diff;
    word_t  btn_flip;

    assign eval_en  = (state_reg == S_WALK) && (cnt_reg != '0);
    assign lock_cur = lock_rd_vld_reg ? lock_rdata : '0;
    assign map_cur  = map_rd_vld_reg ? map_rdata : '0;
    assign diff     = now_reg - lock_cur;
    assign take     = eval_en && chg_reg[ev_pin] && ((win_reg == '0) || !diff[WORD_W-1]);
    assign lock_we  = take && (win_reg != '0);
    assign btn_flip = (map_cur != '0) ? (word_t'(1) << PINSEL_W'(map_cur - 6'd1)) : '0;

    lbdr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_lock_ram (
        .clk   (clk),
        .we    (lock_we),
        .waddr (ev_addr),
        .wdata (until_reg),
        .raddr (rd_addr),
        .rdata (lock_rdata)
    );

    lbdr_ram #(
        .WIDTH (SHIFT_W),
        .DEPTH (DEPTH)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_wr),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (rd_addr),
        .rdata (map_rdata)
    );

    // ------------------------------------------------------------------
    // Close-out of a sample
    // ------------------------------------------------------------------
    logic            out_free;
    logic            finish_go;
    logic [PINS-1:0] acc_final;
    logic            differs;

    assign out_free  = !out_valid_reg || out_ready;
    assign finish_go = (state_reg == S_FINISH) && out_free;
    assign acc_final = (win_reg == '0) ? pins_reg : acc_reg[port_reg];
    assign differs   = (acc_final != last_reg[port_reg]);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start_sample)
                begin
                    state_next = S_WALK;
                    cnt_next   = '0;
                end
            end
            S_WALK:
            begin
                if (int'(cnt_reg) == PINS)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PORTS; p++)
            begin
                win_cfg_reg[p]  <= '0;
                mask_cfg_reg[p] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            for (int p = 0; p < PORTS; p++)
            begin
                if (cfg_addr == 2'(REG_WIN_BASE + 2'(p)))
                begin
                    win_cfg_reg[p] <= cfg_wdata[WIN_W-1:0];
                end
                if (cfg_addr == 2'(REG_MASK_BASE + 2'(p)))
                begin
                    mask_cfg_reg[p] <= cfg_wdata;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request capture (payload, no reset)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (start_sample)
        begin
            port_reg  <= port;
            pins_reg  <= pins_in;
            chg_reg   <= (pins_in ^ acc_reg[port]) & PINS'(mask_in);
            win_reg   <= win_cfg_reg[port];
            now_reg   <= now_ms;
            until_reg <= now_ms + word_t'(win_cfg_reg[port]);
        end
    end

    // ------------------------------------------------------------------
    // Memory valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_vld_reg    <= '0;
            map_vld_reg     <= '0;
            lock_rd_vld_reg <= 1'b0;
            map_rd_vld_reg  <= 1'b0;
        end
        else
        begin
            lock_rd_vld_reg <= lock_vld_reg[rd_addr];
            map_rd_vld_reg  <= map_vld_reg[rd_addr];
            if (lock_we)
            begin
                lock_vld_reg[ev_addr] <= 1'b1;
            end
            if (map_wr)
            begin
                map_vld_reg[map_waddr] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Per-port debounce state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PORTS; p++)
            begin
                acc_reg[p]  <= '0;
                last_reg[p] <= '0;
                btn_reg[p]  <= '0;
            end
        end
        else
        begin
            if (take)
            begin
                btn_reg[port_reg] <= btn_reg[port_reg] ^ btn_flip;
                if (win_reg != '0)
                begin
                    acc_reg[port_reg][ev_pin] <= !acc_reg[port_reg][ev_pin];
                end
            end
            if (finish_go)
            begin
                acc_reg[port_reg] <= acc_final;
                if (differs)
                begin
                    last_reg[port_reg] <= acc_final;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish_go)
        begin
            out_pins_reg <= word_t'(acc_final);
            out_btn_reg  <= btn_reg[port_reg];
            out_chg_reg  <= differs;
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_pins  = out_pins_reg;
    assign buttons        = out_btn_reg;
    assign report_changed = out_chg_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (int'(cnt_reg) <= PINS))
        else $error("pin counter ran past the last pin");

    a_lock_write: assert property (@(posedge clk) disable iff (!rst_n)
        lock_we |-> ((state_reg == S_WALK) && (win_reg != '0) && (cnt_reg != '0)))
        else $error("lockout write outside a windowed walk");

    a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
        finish_go |=> (out_valid_reg && (state_reg == S_IDLE)))
        else $error("finished sample did not produce a result");

    a_map_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (opcode == OP_MAP_WRITE)) |=> ((state_reg == S_IDLE) && $stable(out_valid_reg)
                                                    || (state_reg == S_IDLE) && !out_valid_reg))
        else $error("map write started a walk or produced a result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_pins_reg)))
        else $error("pending result was overwritten");

endmodule : lockout_button_debounce_remap_top

`default_nettype wire
